@@ hw/rtl/cdma_pkg.sv @@
package cdma_pkg;

  localparam int CHUNK_BYTES = 64;
  localparam int DATA_W      = 32;
  localparam int OFF_W       = 6;
  localparam int BYTES_W     = 7;

  localparam logic [DATA_W-1:0] CHUNK_LEN = DATA_W'(CHUNK_BYTES);

  // register map, bus byte offsets
  localparam logic [OFF_W-1:0] OFF_SRC    = 6'h00;
  localparam logic [OFF_W-1:0] OFF_DST    = 6'h08;
  localparam logic [OFF_W-1:0] OFF_LEN    = 6'h10;
  localparam logic [OFF_W-1:0] OFF_CTRL   = 6'h18;
  localparam logic [OFF_W-1:0] OFF_STATUS = 6'h20;

  localparam int START_BIT = 0;

  typedef enum logic [1:0] {
    REQ_BUS_RD  = 2'd0,
    REQ_BUS_WR  = 2'd1,
    REQ_RD_DONE = 2'd2,
    REQ_WR_DONE = 2'd3
  } req_type_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_BUSY = 2'd1,
    ST_DONE = 2'd2
  } status_t;

  localparam logic [1:0] MEM_NONE = 2'd0;
  localparam logic [1:0] MEM_RD   = 2'd1;
  localparam logic [1:0] MEM_WR   = 2'd2;

  typedef struct packed {
    logic [DATA_W-1:0]  read_data;
    logic               bad_offset;
    logic [1:0]         mem_cmd;
    logic [DATA_W-1:0]  mem_addr;
    logic [BYTES_W-1:0] mem_bytes;
  } result_t;

  function automatic logic [DATA_W-1:0] chunk_of(input logic [DATA_W-1:0] len);
    return (len < CHUNK_LEN) ? len : CHUNK_LEN;
  endfunction

endpackage

@@ hw/rtl/chunked_dma_copy_controller.sv @@
// Single-channel chunked DMA copy engine with a bus register file (source, destination,
// length, control, status). Every request (bus read, bus write, memory read-done, memory
// write-done) yields exactly one result carrying read data, an invalid-offset flag and the
// memory request issued, if any. One request is accepted per cycle unless a stalled result
// has filled both registers; its result is presented once it has passed the input register
// and the result register, and the engine state is updated as a request moves between them. A stalled
// result holds the pipeline only once both registers are full.
module chunked_dma_copy_controller (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_req_type,
  input  logic [5:0]  in_reg_offset,
  input  logic [31:0] in_write_data,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_read_data,
  output logic        out_bad_offset,
  output logic [1:0]  out_mem_cmd,
  output logic [31:0] out_mem_addr,
  output logic [6:0]  out_mem_bytes
);

  // input register
  logic                                s1_valid_r;
  logic [1:0]                          s1_type_r;
  logic [cdma_pkg::OFF_W-1:0]          s1_off_r;
  logic [cdma_pkg::DATA_W-1:0]         s1_data_r;

  // engine state
  logic [cdma_pkg::DATA_W-1:0] src_r, src_nxt;
  logic [cdma_pkg::DATA_W-1:0] dst_r, dst_nxt;
  logic [cdma_pkg::DATA_W-1:0] len_r, len_nxt;
  logic [cdma_pkg::DATA_W-1:0] ctrl_r, ctrl_nxt;
  cdma_pkg::status_t           status_r, status_nxt;
  logic                        busy_r, busy_nxt;
  logic                        await_wr_r, await_wr_nxt;

  // result register
  logic              out_valid_r;
  cdma_pkg::result_t res_r, res_nxt;

  logic advance;
  logic [cdma_pkg::DATA_W-1:0] chunk_cur;
  logic [cdma_pkg::DATA_W-1:0] len_sub;
  logic [cdma_pkg::DATA_W-1:0] src_sum;
  logic [cdma_pkg::DATA_W-1:0] chunk_sub;

  assign advance  = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || advance;

  assign chunk_cur = cdma_pkg::chunk_of(len_r);
  assign len_sub   = len_r - chunk_cur;
  assign src_sum   = src_r + chunk_cur;
  assign chunk_sub = cdma_pkg::chunk_of(len_sub);

  always_comb begin
    src_nxt      = src_r;
    dst_nxt      = dst_r;
    len_nxt      = len_r;
    ctrl_nxt     = ctrl_r;
    status_nxt   = status_r;
    busy_nxt     = busy_r;
    await_wr_nxt = await_wr_r;
    res_nxt      = '0;
    case (cdma_pkg::req_type_t'(s1_type_r))
      cdma_pkg::REQ_BUS_RD: begin
        case (s1_off_r)
          cdma_pkg::OFF_SRC:    res_nxt.read_data = src_r;
          cdma_pkg::OFF_DST:    res_nxt.read_data = dst_r;
          cdma_pkg::OFF_LEN:    res_nxt.read_data = len_r;
          cdma_pkg::OFF_CTRL:   res_nxt.read_data = ctrl_r;
          cdma_pkg::OFF_STATUS: res_nxt.read_data = {{(cdma_pkg::DATA_W-2){1'b0}}, status_r};
          default:              res_nxt.bad_offset = 1'b1;
        endcase
      end
      cdma_pkg::REQ_BUS_WR: begin
        case (s1_off_r)
          cdma_pkg::OFF_SRC: src_nxt = s1_data_r;
          cdma_pkg::OFF_DST: dst_nxt = s1_data_r;
          cdma_pkg::OFF_LEN: len_nxt = s1_data_r;
          cdma_pkg::OFF_CTRL: begin
            ctrl_nxt = s1_data_r;
            if (s1_data_r[cdma_pkg::START_BIT] && !busy_r) begin
              await_wr_nxt = 1'b0;
              if (len_r == '0) begin
                status_nxt = cdma_pkg::ST_DONE;
              end else begin
                busy_nxt          = 1'b1;
                status_nxt        = cdma_pkg::ST_BUSY;
                res_nxt.mem_cmd   = cdma_pkg::MEM_RD;
                res_nxt.mem_addr  = src_r;
                res_nxt.mem_bytes = chunk_cur[cdma_pkg::BYTES_W-1:0];
              end
            end
          end
          default: res_nxt.bad_offset = 1'b1;
        endcase
      end
      cdma_pkg::REQ_RD_DONE: begin
        if (busy_r && !await_wr_r) begin
          if (len_r == '0) begin
            // length cleared mid-transfer
            busy_nxt   = 1'b0;
            status_nxt = cdma_pkg::ST_DONE;
          end else begin
            await_wr_nxt      = 1'b1;
            res_nxt.mem_cmd   = cdma_pkg::MEM_WR;
            res_nxt.mem_addr  = dst_r;
            res_nxt.mem_bytes = chunk_cur[cdma_pkg::BYTES_W-1:0];
          end
        end
      end
      cdma_pkg::REQ_WR_DONE: begin
        if (busy_r && await_wr_r) begin
          src_nxt      = src_sum;
          dst_nxt      = dst_r + chunk_cur;
          len_nxt      = len_sub;
          await_wr_nxt = 1'b0;
          if (len_sub == '0) begin
            busy_nxt   = 1'b0;
            status_nxt = cdma_pkg::ST_DONE;
          end else begin
            res_nxt.mem_cmd   = cdma_pkg::MEM_RD;
            res_nxt.mem_addr  = src_sum;
            res_nxt.mem_bytes = chunk_sub[cdma_pkg::BYTES_W-1:0];
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      src_r       <= '0;
      dst_r       <= '0;
      len_r       <= '0;
      ctrl_r      <= '0;
      status_r    <= cdma_pkg::ST_IDLE;
      busy_r      <= 1'b0;
      await_wr_r  <= 1'b0;
    end else begin
      if (in_ready) begin
        s1_valid_r <= in_valid;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
        src_r       <= src_nxt;
        dst_r       <= dst_nxt;
        len_r       <= len_nxt;
        ctrl_r      <= ctrl_nxt;
        status_r    <= status_nxt;
        busy_r      <= busy_nxt;
        await_wr_r  <= await_wr_nxt;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_type_r <= in_req_type;
      s1_off_r  <= in_reg_offset;
      s1_data_r <= in_write_data;
    end
    if (advance) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_read_data  = res_r.read_data;
  assign out_bad_offset = res_r.bad_offset;
  assign out_mem_cmd    = res_r.mem_cmd;
  assign out_mem_addr   = res_r.mem_addr;
  assign out_mem_bytes  = res_r.mem_bytes;

endmodule

@@ hw/rtl/cdma_checker.sv @@
module cdma_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_read_data,
  input logic        out_bad_offset,
  input logic [1:0]  out_mem_cmd,
  input logic [31:0] out_mem_addr,
  input logic [6:0]  out_mem_bytes
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_mem_cmd) && $stable(out_mem_addr)
      && $stable(out_read_data) && $stable(out_bad_offset) && $stable(out_mem_bytes))
    else $error("stalled result changed");

  // a bad bus access never issues a memory request
  a_bad_no_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_bad_offset |-> out_mem_cmd == cdma_pkg::MEM_NONE && out_read_data == '0)
    else $error("bad offset with memory request or data");

  // no request means empty address and count
  a_idle_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_mem_cmd == cdma_pkg::MEM_NONE |-> out_mem_addr == '0 && out_mem_bytes == '0)
    else $error("address or count without a memory request");

  // read data only comes from bus reads, which issue nothing
  a_rd_no_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_read_data != '0 |-> out_mem_cmd == cdma_pkg::MEM_NONE)
    else $error("read data alongside a memory request");

  // with the result register free, a request is taken
  a_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid && in_valid |-> in_ready)
    else $error("request refused with an empty pipeline");

endmodule

bind chunked_dma_copy_controller cdma_checker u_cdma_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_ready       (in_ready),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_read_data  (out_read_data),
  .out_bad_offset (out_bad_offset),
  .out_mem_cmd    (out_mem_cmd),
  .out_mem_addr   (out_mem_addr),
  .out_mem_bytes  (out_mem_bytes)
);

@@ bench/tb_chunked_dma_copy_controller.sv @@
`timescale 1ns / 1ps

module tb_chunked_dma_copy_controller;

  typedef struct {
    cdma_pkg::req_type_t                 kind;
    logic [cdma_pkg::OFF_W-1:0]          off;
    logic [cdma_pkg::DATA_W-1:0]         data;
    bit                                  typed;
    cdma_pkg::result_t                   res;
  } dir_row_t;

  localparam cdma_pkg::result_t NO_RES = '0;
  localparam cdma_pkg::result_t BAD_RES = '{read_data: '0, bad_offset: 1'b1,
                                            mem_cmd: cdma_pkg::MEM_NONE,
                                            mem_addr: '0, mem_bytes: '0};
  localparam cdma_pkg::result_t DONE_RES = '{
    read_data: cdma_pkg::DATA_W'(cdma_pkg::ST_DONE), bad_offset: 1'b0,
    mem_cmd: cdma_pkg::MEM_NONE, mem_addr: '0, mem_bytes: '0};

  logic                         clk = 1'b0;
  logic                         rst_n = 1'b0;
  logic                         in_valid = 1'b0;
  logic                         in_ready;
  logic [1:0]                   in_req_type = cdma_pkg::REQ_BUS_RD;
  logic [cdma_pkg::OFF_W-1:0]   in_reg_offset = '0;
  logic [cdma_pkg::DATA_W-1:0]  in_write_data = '0;
  logic                         out_valid;
  logic                         out_ready = 1'b0;
  logic [cdma_pkg::DATA_W-1:0]  out_read_data;
  logic                         out_bad_offset;
  logic [1:0]                   out_mem_cmd;
  logic [cdma_pkg::DATA_W-1:0]  out_mem_addr;
  logic [cdma_pkg::BYTES_W-1:0] out_mem_bytes;

  // engine state as the predictor sees it
  logic [cdma_pkg::DATA_W-1:0] eng_src, eng_dst, eng_len, eng_ctrl;
  cdma_pkg::status_t           eng_status;
  logic                        eng_busy, eng_wait_wr;

  cdma_pkg::result_t dma_results_due[$];
  dir_row_t          directed_rows[$];
  int       in_idle_pct, out_stall_pct;
  int       req_count, fail_count, n_mem_rd, n_mem_wr, n_bad, n_done, n_checked;
  int       in_pcts[4] = '{0, 74, 0, 30};
  int       out_pcts[4] = '{0, 0, 74, 30};

  chunked_dma_copy_controller i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_req_type    (in_req_type),
    .in_reg_offset  (in_reg_offset),
    .in_write_data  (in_write_data),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_read_data  (out_read_data),
    .out_bad_offset (out_bad_offset),
    .out_mem_cmd    (out_mem_cmd),
    .out_mem_addr   (out_mem_addr),
    .out_mem_bytes  (out_mem_bytes)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #1000000;
    $display("tb_chunked_dma_copy_controller failed");
    $finish;
  end

  function automatic logic [cdma_pkg::DATA_W-1:0] chunk_left();
    return (eng_len < cdma_pkg::DATA_W'(cdma_pkg::CHUNK_BYTES)) ?
           eng_len : cdma_pkg::DATA_W'(cdma_pkg::CHUNK_BYTES);
  endfunction

  // issue the next read, or finish when the length has run out
  function automatic cdma_pkg::result_t next_read();
    cdma_pkg::result_t r;
    logic [cdma_pkg::DATA_W-1:0] c;
    r = '0;
    eng_wait_wr = 1'b0;
    if (eng_len == '0) begin
      eng_busy = 1'b0;
      eng_status = cdma_pkg::ST_DONE;
    end else begin
      c = chunk_left();
      r.mem_cmd = cdma_pkg::MEM_RD;
      r.mem_addr = eng_src;
      r.mem_bytes = c[cdma_pkg::BYTES_W-1:0];
    end
    return r;
  endfunction

  function automatic cdma_pkg::result_t predict_dma_result(
      cdma_pkg::req_type_t kind, logic [cdma_pkg::OFF_W-1:0] off,
      logic [cdma_pkg::DATA_W-1:0] wd);
    cdma_pkg::result_t r;
    logic [cdma_pkg::DATA_W-1:0] c;
    r = '0;
    case (kind)
      cdma_pkg::REQ_BUS_RD: begin
        case (off)
          cdma_pkg::OFF_SRC:    r.read_data = eng_src;
          cdma_pkg::OFF_DST:    r.read_data = eng_dst;
          cdma_pkg::OFF_LEN:    r.read_data = eng_len;
          cdma_pkg::OFF_CTRL:   r.read_data = eng_ctrl;
          cdma_pkg::OFF_STATUS: r.read_data = cdma_pkg::DATA_W'(eng_status);
          default:              r.bad_offset = 1'b1;
        endcase
      end
      cdma_pkg::REQ_BUS_WR: begin
        case (off)
          cdma_pkg::OFF_SRC: eng_src = wd;
          cdma_pkg::OFF_DST: eng_dst = wd;
          cdma_pkg::OFF_LEN: eng_len = wd;
          cdma_pkg::OFF_CTRL: begin
            eng_ctrl = wd;
            if (wd[cdma_pkg::START_BIT] && !eng_busy) begin
              eng_busy = 1'b1;
              eng_status = cdma_pkg::ST_BUSY;
              r = next_read();
            end
          end
          default: r.bad_offset = 1'b1;
        endcase
      end
      cdma_pkg::REQ_RD_DONE: begin
        if (eng_busy && !eng_wait_wr) begin
          if (eng_len == '0) begin
            r = next_read();
          end else begin
            c = chunk_left();
            eng_wait_wr = 1'b1;
            r.mem_cmd = cdma_pkg::MEM_WR;
            r.mem_addr = eng_dst;
            r.mem_bytes = c[cdma_pkg::BYTES_W-1:0];
          end
        end
      end
      default: begin
        if (eng_busy && eng_wait_wr) begin
          c = chunk_left();
          eng_src = eng_src + c;
          eng_dst = eng_dst + c;
          eng_len = eng_len - c;
          r = next_read();
        end
      end
    endcase
    return r;
  endfunction

  // drive one request, wait for it to be taken, then queue what it should produce
  task automatic send_req(cdma_pkg::req_type_t kind, logic [cdma_pkg::OFF_W-1:0] off,
                          logic [cdma_pkg::DATA_W-1:0] wd, bit typed = 1'b0,
                          cdma_pkg::result_t typed_res = '0);
    cdma_pkg::result_t r;
    logic busy_prev, start_idle;
    while ($urandom_range(0, 99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req_type <= kind;
    in_reg_offset <= off;
    in_write_data <= wd;
    do @(posedge clk); while (!in_ready);
    busy_prev = eng_busy;
    start_idle = kind == cdma_pkg::REQ_BUS_WR && off == cdma_pkg::OFF_CTRL
                 && wd[cdma_pkg::START_BIT] && !eng_busy;
    r = predict_dma_result(kind, off, wd);
    dma_results_due.push_back(typed ? typed_res : r);
    req_count++;
    if (r.mem_cmd == cdma_pkg::MEM_RD) n_mem_rd++;
    if (r.mem_cmd == cdma_pkg::MEM_WR) n_mem_wr++;
    if (r.bad_offset) n_bad++;
    // a transfer ends on a completion, or at once on a zero-length start
    if (eng_status == cdma_pkg::ST_DONE && !eng_busy && (busy_prev || start_idle)) n_done++;
  endtask

  function automatic logic [cdma_pkg::OFF_W-1:0] pick_offset();
    case ($urandom_range(0, 5))
      0: return cdma_pkg::OFF_SRC;
      1: return cdma_pkg::OFF_DST;
      2: return cdma_pkg::OFF_LEN;
      3: return cdma_pkg::OFF_CTRL;
      4: return cdma_pkg::OFF_STATUS;
      default: return cdma_pkg::OFF_W'($urandom_range(0, 63));
    endcase
  endfunction

  task automatic send_noise();
    send_req(cdma_pkg::req_type_t'($urandom_range(0, 3)), pick_offset(), $urandom);
  endtask

  // program a copy and walk it through its chunks, with some noise in between
  task automatic run_copy();
    logic [cdma_pkg::DATA_W-1:0] len;
    int chunks;
    len = ($urandom_range(0, 9) == 0) ? cdma_pkg::DATA_W'($urandom) :
          cdma_pkg::DATA_W'($urandom_range(0, 300));
    send_req(cdma_pkg::REQ_BUS_WR, cdma_pkg::OFF_SRC, $urandom);
    send_req(cdma_pkg::REQ_BUS_WR, cdma_pkg::OFF_DST, $urandom);
    send_req(cdma_pkg::REQ_BUS_WR, cdma_pkg::OFF_LEN, len);
    send_req(cdma_pkg::REQ_BUS_WR, cdma_pkg::OFF_CTRL, $urandom | 32'h1);
    chunks = 0;
    while (eng_busy) begin
      if (chunks >= 6 || $urandom_range(0, 19) == 0) begin
        send_req(cdma_pkg::REQ_BUS_WR, cdma_pkg::OFF_LEN, '0);
      end
      if ($urandom_range(0, 3) == 0) begin
        if ($urandom_range(0, 1) == 0) begin
          send_req(cdma_pkg::REQ_BUS_RD, pick_offset(), $urandom);
        end else begin
          send_req(eng_wait_wr ? cdma_pkg::REQ_RD_DONE : cdma_pkg::REQ_WR_DONE,
                   pick_offset(), $urandom);
        end
      end
      if (eng_wait_wr) begin
        send_req(cdma_pkg::REQ_WR_DONE, pick_offset(), $urandom);
        chunks++;
      end else begin
        send_req(cdma_pkg::REQ_RD_DONE, pick_offset(), $urandom);
      end
    end
    send_req(cdma_pkg::REQ_BUS_RD, cdma_pkg::OFF_STATUS, $urandom);
  endtask

  // result side: check against the oldest expectation, then pick next ready
  always @(posedge clk) begin
    cdma_pkg::result_t exp_r;
    if (rst_n && out_valid && out_ready) begin
      if (dma_results_due.size() == 0) begin
        $error("result with no request outstanding");
        fail_count++;
      end else begin
        exp_r = dma_results_due.pop_front();
        n_checked++;
        if (out_read_data !== exp_r.read_data) begin
          $error("read_data: expected %h, got %h", exp_r.read_data, out_read_data);
          fail_count++;
        end
        if (out_bad_offset !== exp_r.bad_offset) begin
          $error("bad_offset: expected %b, got %b", exp_r.bad_offset, out_bad_offset);
          fail_count++;
        end
        if (out_mem_cmd !== exp_r.mem_cmd) begin
          $error("mem_cmd: expected %0d, got %0d", exp_r.mem_cmd, out_mem_cmd);
          fail_count++;
        end
        if (out_mem_addr !== exp_r.mem_addr) begin
          $error("mem_addr: expected %h, got %h", exp_r.mem_addr, out_mem_addr);
          fail_count++;
        end
        if (out_mem_bytes !== exp_r.mem_bytes) begin
          $error("mem_bytes: expected %0d, got %0d", exp_r.mem_bytes, out_mem_bytes);
          fail_count++;
        end
      end
    end
    out_ready <= ($urandom_range(0, 99) >= out_stall_pct);
  end

  initial begin
    int target, drain;
    eng_src = '0;
    eng_dst = '0;
    eng_len = '0;
    eng_ctrl = '0;
    eng_status = cdma_pkg::ST_IDLE;
    eng_busy = 1'b0;
    eng_wait_wr = 1'b0;
    in_idle_pct = 0;
    out_stall_pct = 0;

    directed_rows.push_back('{cdma_pkg::REQ_BUS_RD, cdma_pkg::OFF_SRC, 32'h0,
                              1'b1, NO_RES});
    directed_rows.push_back('{cdma_pkg::REQ_BUS_RD, cdma_pkg::OFF_DST, 32'hffff_ffff,
                              1'b1, NO_RES});
    directed_rows.push_back('{cdma_pkg::REQ_BUS_RD, cdma_pkg::OFF_LEN, 32'h0,
                              1'b1, NO_RES});
    directed_rows.push_back('{cdma_pkg::REQ_BUS_RD, cdma_pkg::OFF_CTRL, 32'h0,
                              1'b1, NO_RES});
    directed_rows.push_back('{cdma_pkg::REQ_BUS_RD, cdma_pkg::OFF_STATUS, 32'h0,
                              1'b1, NO_RES});
    directed_rows.push_back('{cdma_pkg::REQ_BUS_RD, 6'h3f, 32'h0, 1'b1, BAD_RES});
    // status is read only
    directed_rows.push_back('{cdma_pkg::REQ_BUS_WR, cdma_pkg::OFF_STATUS, 32'hffff_ffff,
                              1'b1, BAD_RES});
    directed_rows.push_back('{cdma_pkg::REQ_BUS_WR, 6'h04, 32'h1234_5678, 1'b1, BAD_RES});
    // completions while idle are dropped
    directed_rows.push_back('{cdma_pkg::REQ_RD_DONE, 6'h3f, 32'hffff_ffff, 1'b1, NO_RES});
    directed_rows.push_back('{cdma_pkg::REQ_WR_DONE, cdma_pkg::OFF_SRC, 32'h0,
                              1'b1, NO_RES});
    // zero length start finishes at once
    directed_rows.push_back('{cdma_pkg::REQ_BUS_WR, cdma_pkg::OFF_LEN, 32'h0,
                              1'b1, NO_RES});
    directed_rows.push_back('{cdma_pkg::REQ_BUS_WR, cdma_pkg::OFF_CTRL, 32'h1,
                              1'b1, NO_RES});
    directed_rows.push_back('{cdma_pkg::REQ_BUS_RD, cdma_pkg::OFF_STATUS, 32'h0,
                              1'b1, DONE_RES});
    // copy across the top of the address space
    directed_rows.push_back('{cdma_pkg::REQ_BUS_WR, cdma_pkg::OFF_SRC, 32'hffff_ffc0,
                              1'b0, NO_RES});
    directed_rows.push_back('{cdma_pkg::REQ_BUS_WR, cdma_pkg::OFF_DST, 32'h0000_0010,
                              1'b0, NO_RES});
    directed_rows.push_back('{cdma_pkg::REQ_BUS_WR, cdma_pkg::OFF_LEN, 32'd130,
                              1'b0, NO_RES});
    directed_rows.push_back('{cdma_pkg::REQ_BUS_WR, cdma_pkg::OFF_CTRL, 32'hffff_ffff,
                              1'b0, NO_RES});
    directed_rows.push_back('{cdma_pkg::REQ_WR_DONE, cdma_pkg::OFF_DST, 32'h0,
                              1'b0, NO_RES});
    directed_rows.push_back('{cdma_pkg::REQ_RD_DONE, 6'h3f, 32'hdead_beef, 1'b0, NO_RES});
    // start again while busy
    directed_rows.push_back('{cdma_pkg::REQ_BUS_WR, cdma_pkg::OFF_CTRL, 32'h1,
                              1'b0, NO_RES});
    directed_rows.push_back('{cdma_pkg::REQ_RD_DONE, cdma_pkg::OFF_SRC, 32'h0,
                              1'b0, NO_RES});
    directed_rows.push_back('{cdma_pkg::REQ_WR_DONE, cdma_pkg::OFF_LEN, 32'h0,
                              1'b0, NO_RES});
    directed_rows.push_back('{cdma_pkg::REQ_RD_DONE, cdma_pkg::OFF_CTRL, 32'h0,
                              1'b0, NO_RES});
    directed_rows.push_back('{cdma_pkg::REQ_WR_DONE, cdma_pkg::OFF_STATUS, 32'h0,
                              1'b0, NO_RES});
    // length cleared while a read is pending
    directed_rows.push_back('{cdma_pkg::REQ_BUS_WR, cdma_pkg::OFF_LEN, 32'h0,
                              1'b0, NO_RES});
    directed_rows.push_back('{cdma_pkg::REQ_RD_DONE, cdma_pkg::OFF_SRC, 32'h0,
                              1'b0, NO_RES});
    directed_rows.push_back('{cdma_pkg::REQ_BUS_RD, cdma_pkg::OFF_STATUS, 32'h0,
                              1'b1, DONE_RES});

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) begin
      send_req(directed_rows[i].kind, directed_rows[i].off, directed_rows[i].data,
               directed_rows[i].typed, directed_rows[i].res);
    end

    target = req_count;
    for (int p = 0; p < 4; p++) begin
      in_idle_pct = in_pcts[p];
      out_stall_pct = out_pcts[p];
      target += 155;
      while (req_count < target) begin
        if ($urandom_range(0, 9) < 7) begin
          run_copy();
        end else begin
          send_noise();
        end
      end
    end
    in_valid <= 1'b0;
    out_stall_pct = 0;

    drain = 0;
    while (dma_results_due.size() != 0 && drain < 5000) begin
      @(posedge clk);
      drain++;
    end
    if (dma_results_due.size() != 0) begin
      $error("%0d results never arrived", dma_results_due.size());
      fail_count++;
    end
    repeat (10) @(posedge clk);

    $display("%0d requests, %0d results checked: %0d memory reads, %0d memory writes",
             req_count, n_checked, n_mem_rd, n_mem_wr);
    $display("%0d invalid offsets, %0d copies finished by a completion or start",
             n_bad, n_done);
    if (fail_count == 0) begin
      $display("tb_chunked_dma_copy_controller passed");
    end else begin
      $display("tb_chunked_dma_copy_controller failed");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
hw/rtl/cdma_pkg.sv
hw/rtl/chunked_dma_copy_controller.sv
hw/rtl/cdma_checker.sv
bench/tb_chunked_dma_copy_controller.sv
